@@ src/sum_checked_frame_decoder_macros.svh @@
// Assertion macros shared by the frame decoder RTL.
`ifndef SUM_CHECKED_FRAME_DECODER_MACROS_SVH
`define SUM_CHECKED_FRAME_DECODER_MACROS_SVH
`ifndef SYNTH
// Plain property check, disabled while reset is held.
`define SCFD_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scfd assertion failed");
// Same-cycle implication check.
`define SCFD_ASSERT_IMP(name, ante, cons, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfd implication failed");
// Next-cycle implication check.
`define SCFD_ASSERT_NEXT(name, ante, cons, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfd next-cycle implication failed");
`else
`define SCFD_ASSERT(name, prop, clk, rst_n)
`define SCFD_ASSERT_IMP(name, ante, cons, clk, rst_n)
`define SCFD_ASSERT_NEXT(name, ante, cons, clk, rst_n)
`endif
`endif

@@ src/scfd_pkg.sv @@
// Constants and types of the sum-checked frame decoder.
package scfd_pkg;

  // Frame delimiters
  localparam logic [7:0] HeadFirst  = 8'hAA;
  localparam logic [7:0] HeadSecond = 8'h55;
  localparam logic [7:0] TailFirst  = 8'hA0;
  localparam logic [7:0] TailSecond = 8'h5F;

  // Frame positions
  localparam int unsigned PosWidth  = 12;
  localparam int unsigned GroupPos  = 2;
  localparam int unsigned SumPos    = 7;
  localparam int unsigned LastBase  = 9;   // last position of a frame with no groups
  localparam int unsigned CapBase   = 3;
  localparam int unsigned CapDepth  = 14;

  // Offsets into the capture bank (position minus CapBase)
  localparam int unsigned CapCommand  = 0;
  localparam int unsigned CapAddress  = 1;
  localparam int unsigned CapPort     = 2;
  localparam int unsigned CapData     = 3;
  localparam int unsigned CapSum      = 4;
  localparam int unsigned CapDestX    = 5;
  localparam int unsigned CapDestZ    = 7;
  localparam int unsigned CapTray     = 9;
  localparam int unsigned CapCarrierX = 10;
  localparam int unsigned CapCarrierZ = 12;

  typedef logic [PosWidth-1:0] pos_t;
  typedef logic [CapDepth-1:0][7:0] cap_bank_t;

  // One decoded frame
  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  group_count;
    logic [7:0]  command;
    logic [7:0]  port_byte;
    logic [7:0]  command_data;
    logic [15:0] dest_x;
    logic [15:0] dest_z;
    logic [7:0]  tray_attribute;
    logic [15:0] carrier_x;
    logic [15:0] carrier_z;
  } frame_result_t;

endpackage

@@ src/sum_checked_frame_decoder.sv @@
// Sum-checked frame decoder: byte stream in, one decoded frame result out.
`include "sum_checked_frame_decoder_macros.svh"

// Takes one received byte per clock cycle. A frame is 0xAA 0x55, group count,
// command, address, port byte, command data, sum byte, eight payload bytes per
// group and the trailer 0xA0 0x5F; its end is found by counting bytes. The
// position counter, running sum and capture bank update with each byte taken,
// and on the last byte of a frame the decoded result is loaded into the result
// register, where it appears in the cycle after that byte is taken. Input is
// stalled only on a frame's last byte while the previous result is still held
// and stalled downstream; every other byte is taken in the cycle it is offered.
// The local address register is written through the configuration channel,
// which is always ready, and should only change while no frame is in progress.
module sum_checked_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // decoded frames
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [7:0]  group_count_o,
  output logic [7:0]  command_o,
  output logic [7:0]  port_byte_o,
  output logic [7:0]  command_data_o,
  output logic [15:0] dest_x_o,
  output logic [15:0] dest_z_o,
  output logic [7:0]  tray_attribute_o,
  output logic [15:0] carrier_x_o,
  output logic [15:0] carrier_z_o
);
  import scfd_pkg::*;

  logic          cfg_write;
  logic [7:0]    local_addr_q;
  pos_t          pos_q, pos_d;
  logic [7:0]    groups_q, groups_d;
  logic [7:0]    sum_q, sum_d;
  logic          hdr_q, hdr_d;
  cap_bank_t     cap_q, cap_d, cap_nx;
  logic [7:0]    prev_q, prev_d;
  logic          out_valid_q, out_valid_d;
  frame_result_t res_q, res_d, res_nx;
  pos_t          end_pos, sum_hi;
  logic          is_last, in_acc, load, frame_ok;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= 8'h00;
    end else if (cfg_write) begin
      local_addr_q <= cfg_data_i;
    end
  end

  // Frame end and sum window from the stored group count
  assign end_pos = pos_t'(LastBase) + {1'b0, groups_q, 3'b000};
  assign sum_hi  = pos_t'(SumPos) + {1'b0, groups_q, 3'b000};
  assign is_last = (pos_q == end_pos);

  // Handshakes
  assign in_stall_o = out_valid_q & out_stall_i & is_last;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign load       = in_acc & is_last;

  // Capture bank with the current beat written in
  always_comb begin
    cap_nx = cap_q;
    for (int i = 0; i < CapDepth; i++) begin
      if (pos_q == pos_t'(CapBase + i)) begin
        cap_nx[i] = rx_byte_i;
      end
    end
  end

  // Result of the frame ending with this beat
  assign frame_ok = hdr_q && (sum_q == cap_nx[CapSum]) &&
                    (cap_nx[CapAddress] == local_addr_q) &&
                    (prev_q == TailFirst) && (rx_byte_i == TailSecond);

  always_comb begin
    res_nx = '0;
    if (frame_ok) begin
      res_nx.frame_ok       = 1'b1;
      res_nx.group_count    = groups_q;
      res_nx.command        = cap_nx[CapCommand];
      res_nx.port_byte      = cap_nx[CapPort];
      res_nx.command_data   = cap_nx[CapData];
      res_nx.dest_x         = {cap_nx[CapDestX], cap_nx[CapDestX+1]};
      res_nx.dest_z         = {cap_nx[CapDestZ], cap_nx[CapDestZ+1]};
      res_nx.tray_attribute = cap_nx[CapTray];
      res_nx.carrier_x      = {cap_nx[CapCarrierX], cap_nx[CapCarrierX+1]};
      res_nx.carrier_z      = {cap_nx[CapCarrierZ], cap_nx[CapCarrierZ+1]};
    end
  end

  // Frame state update per accepted beat
  always_comb begin
    pos_d    = pos_q;
    groups_d = groups_q;
    sum_d    = sum_q;
    hdr_d    = hdr_q;
    cap_d    = cap_q;
    prev_d   = prev_q;
    if (in_acc) begin
      prev_d = rx_byte_i;
      if (pos_q == '0) begin
        hdr_d = (rx_byte_i == HeadFirst);
      end else if (pos_q == pos_t'(1)) begin
        hdr_d = hdr_q && (rx_byte_i == HeadSecond);
      end else if (pos_q == pos_t'(GroupPos)) begin
        groups_d = rx_byte_i;
      end
      // sum window: group count up to the last payload byte, sum byte left out
      if ((pos_q >= pos_t'(GroupPos)) && (pos_q != pos_t'(SumPos)) &&
          ((pos_q == pos_t'(GroupPos)) || (pos_q <= sum_hi))) begin
        sum_d = sum_q + rx_byte_i;
      end
      cap_d = cap_nx;
      if (is_last) begin
        pos_d    = '0;
        groups_d = 8'h00;
        sum_d    = 8'h00;
        hdr_d    = 1'b1;
        cap_d    = '0;
      end else begin
        pos_d = pos_q + pos_t'(1);
      end
    end
  end

  // Result register, emptied when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    res_d       = res_q;
    if (load) begin
      out_valid_d = 1'b1;
      res_d       = res_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      groups_q    <= 8'h00;
      sum_q       <= 8'h00;
      hdr_q       <= 1'b1;
      cap_q       <= '0;
      prev_q      <= 8'h00;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      pos_q       <= pos_d;
      groups_q    <= groups_d;
      sum_q       <= sum_d;
      hdr_q       <= hdr_d;
      cap_q       <= cap_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  // Outputs
  assign out_valid_o      = out_valid_q;
  assign frame_ok_o       = res_q.frame_ok;
  assign group_count_o    = res_q.group_count;
  assign command_o        = res_q.command;
  assign port_byte_o      = res_q.port_byte;
  assign command_data_o   = res_q.command_data;
  assign dest_x_o         = res_q.dest_x;
  assign dest_z_o         = res_q.dest_z;
  assign tray_attribute_o = res_q.tray_attribute;
  assign carrier_x_o      = res_q.carrier_x;
  assign carrier_z_o      = res_q.carrier_z;

  // Checks
  `SCFD_ASSERT(a_pos_in_frame, pos_q <= end_pos, clk_i, rst_ni)
  `SCFD_ASSERT_IMP(a_no_overwrite, load, !(out_valid_q && out_stall_i), clk_i, rst_ni)
  `SCFD_ASSERT_IMP(a_result_from_last, $rose(out_valid_q), $past(load), clk_i, rst_ni)
  `SCFD_ASSERT_NEXT(a_clear_after_end, load, (pos_q == '0) && (sum_q == 8'h00), clk_i, rst_ni)
  `SCFD_ASSERT_IMP(a_reject_zero, !res_q.frame_ok, res_q == '0, clk_i, rst_ni)

endmodule
